FILE: sv/nth_weekday_of_month_unit_assert.svh
// Assertion macros used by the checker of the nth weekday unit.
`ifndef NTH_WEEKDAY_OF_MONTH_UNIT_ASSERT_SVH
`define NTH_WEEKDAY_OF_MONTH_UNIT_ASSERT_SVH

// Plain clocked property.
`define NWOM_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked property, switched off while the reset is held.
`define NWOM_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: sv/nwom_pkg.sv
// ----------------------------------------------------------------------------
// nwom_pkg
// Widths, limits, reciprocal constants and month tables of the nth weekday
// of month unit.
// ----------------------------------------------------------------------------
package nwom_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned OCC_W   = 3;
   localparam int unsigned WDAY_W  = 3;
   localparam int unsigned DAY_W   = 23;

   // accept edge to the edge that takes the result
   localparam int unsigned PIPE_LATENCY = 7;

   localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
   localparam logic [OCC_W-1:0]   OCC_FIRST  = 3'd1;
   localparam logic [WDAY_W-1:0]  WDAY_LAST  = 3'd6;

   localparam logic signed [DAY_W-1:0] DAY_MIN = -23'sd719162;
   localparam logic signed [DAY_W-1:0] DAY_MAX = 23'sd2932896;

   // days from 0000-03-01 to 1970-01-01
   localparam logic signed [DAY_W-1:0] EPOCH_OFFSET = 23'sd719468;

   // floor(x/400) = (x*RECIP_400) >> 21, floor(x/100) = (x*RECIP_100) >> 22,
   // exact over the year range; floor(x/7) = (x*RECIP_7) >> 21 below 2^18
   localparam logic [12:0] RECIP_400 = 13'd5243;
   localparam logic [15:0] RECIP_100 = 16'd41944;
   localparam logic [18:0] RECIP_7   = 19'd299594;

   // day within the March-based year of the first of a month
   function automatic logic [8:0] day_of_year(input logic [MONTH_W-1:0] month);
      logic [8:0] d;
      case (month)
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         4'd12:   d = 9'd275;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] month_length(input logic [MONTH_W-1:0] month,
                                               input logic leap);
      logic [4:0] d;
      case (month)
         4'd2:    d = leap ? 5'd29 : 5'd28;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

FILE: sv/nth_weekday_of_month_unit.sv
// ----------------------------------------------------------------------------
// nth_weekday_of_month_unit
// Day count since 1970-01-01 of the nth given weekday of a Gregorian month.
// ----------------------------------------------------------------------------
// Use:
//   A request word (year, month, occurrence, weekday with Monday = 0) is
//   taken at a rising edge with start high and busy low. busy only follows
//   reset, so one word can be taken every cycle.
//   The answer appears on rsp_day_number with rsp_valid high for exactly one
//   cycle, once the word has passed pipeline stages A to G; answers leave in
//   request order. An occurrence past the month's end gives the last such
//   weekday. Out-of-range fields are clamped (year 1..9999, month 1..12,
//   weekday 7 as Sunday, occurrence 0 as first).
//   Throughput is one word per cycle outside reset through a seven-stage
//   pipeline that holds the reciprocal multiplications for /400 and /100
//   (stage B) and for /7 (stage E), and the day-count sums.
//   Reset empties the pipeline; words in flight are dropped and no answer
//   leaves after it. The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module nth_weekday_of_month_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [nwom_pkg::YEAR_W-1:0]           req_year,
   input  logic [nwom_pkg::MONTH_W-1:0]          req_month,
   input  logic [nwom_pkg::OCC_W-1:0]            req_occurrence,
   input  logic [nwom_pkg::WDAY_W-1:0]           req_weekday,
   output logic                                  rsp_valid,
   output logic signed [nwom_pkg::DAY_W-1:0]     rsp_day_number
);

   import nwom_pkg::*;

   // reduce 0..13 into 0..6
   function automatic logic [2:0] wrap7(input logic [3:0] v);
      logic [3:0] r;
      r = (v >= 4'd7) ? v - 4'd7 : v;
      return r[2:0];
   endfunction

   logic [6:0] valid_ff, valid_in;

   // stage A: clamped fields
   logic [YEAR_W-1:0]  a_year_ff, a_year_in, a_yy_ff, a_yy_in;
   logic [MONTH_W-1:0] a_month_ff, a_month_in;
   logic [OCC_W-1:0]   a_occ_ff, a_occ_in;
   logic [WDAY_W-1:0]  a_wday_ff, a_wday_in;
   // stage B: quotients
   logic [YEAR_W-1:0]  b_year_ff, b_yy_ff;
   logic [MONTH_W-1:0] b_month_ff;
   logic [OCC_W-1:0]   b_occ_ff;
   logic [WDAY_W-1:0]  b_wday_ff;
   logic [4:0]         b_era_ff, b_era_in;
   logic [6:0]         b_q100_ff, b_q100_in;
   logic [26:0]        yy_prod;
   logic [29:0]        year_prod;
   // stage C: year of era, month tables
   logic [4:0]         c_era_ff;
   logic [8:0]         c_yoe_ff, c_yoe_in;
   logic [8:0]         c_doy_ff;
   logic [4:0]         c_dim_ff, c_dim_in;
   logic [OCC_W-1:0]   c_occ_ff;
   logic [WDAY_W-1:0]  c_wday_ff;
   logic [YEAR_W-1:0]  yoe_full, r100_full;
   logic               leap;
   // stage D: day of era
   logic [4:0]         d_era_ff;
   logic [17:0]        d_doe_ff, d_doe_in;
   logic [4:0]         d_dim_ff;
   logic [OCC_W-1:0]   d_occ_ff;
   logic [WDAY_W-1:0]  d_wday_ff;
   logic [14:0]        yoe_x41;
   // stage E: first of month, weekday quotient
   logic signed [DAY_W-1:0] e_first_ff, e_first_in;
   logic [17:0]        e_x_ff, e_x_in;
   logic [14:0]        e_q7_ff, e_q7_in;
   logic [4:0]         e_dim_ff;
   logic [OCC_W-1:0]   e_occ_ff;
   logic [WDAY_W-1:0]  e_wday_ff;
   logic [21:0]        era_days;
   logic [35:0]        x_prod;
   // stage F: weekday of the first
   logic signed [DAY_W-1:0] f_first_ff;
   logic [2:0]         f_wf_ff, f_wf_in;
   logic [5:0]         f_weeks_ff, f_weeks_in;
   logic [4:0]         f_dm1_ff, f_dm1_in;
   logic [WDAY_W-1:0]  f_wday_ff;
   logic [17:0]        wf_full;
   // stage G: result
   logic signed [DAY_W-1:0] g_day_ff, g_day_in;
   logic [2:0]         fwd, wl, back, dm7;
   logic [5:0]         tgt, delta;

   assign busy = reset;

   always_comb begin
      valid_in = {valid_ff[5:0], start & ~busy};

      a_year_in  = (req_year < YEAR_MIN) ? YEAR_MIN :
                   (req_year > YEAR_MAX) ? YEAR_MAX : req_year;
      a_month_in = (req_month < MONTH_JAN) ? MONTH_JAN :
                   (req_month > MONTH_DEC) ? MONTH_DEC : req_month;
      a_occ_in   = (req_occurrence < OCC_FIRST) ? OCC_FIRST : req_occurrence;
      a_wday_in  = (req_weekday > WDAY_LAST) ? WDAY_LAST : req_weekday;
      // January and February count with the year before
      a_yy_in    = (a_month_in <= MONTH_FEB) ? a_year_in - 14'd1 : a_year_in;

      yy_prod   = 27'(a_yy_ff) * 27'(RECIP_400);
      year_prod = 30'(a_year_ff) * 30'(RECIP_100);
      b_era_in  = yy_prod[25:21];
      b_q100_in = year_prod[28:22];

      yoe_full  = b_yy_ff - 14'(b_era_ff) * 14'd400;
      r100_full = b_year_ff - 14'(b_q100_ff) * 14'd100;
      c_yoe_in  = yoe_full[8:0];
      // divisible by 100 and by 400 means century quotient divisible by 4
      leap      = (b_year_ff[1:0] == 2'd0) &&
                  ((r100_full[6:0] != 7'd0) || (b_q100_ff[1:0] == 2'd0));
      c_dim_in  = month_length(b_month_ff, leap);

      yoe_x41  = 15'(c_yoe_ff) * 15'd41;
      d_doe_in = 18'(c_yoe_ff) * 18'd365 + 18'(c_yoe_ff[8:2])
               - 18'(yoe_x41[14:12]) + 18'(c_doy_ff);

      era_days   = 22'(d_era_ff) * 22'd146097;
      e_first_in = $signed({1'b0, era_days}) + $signed({5'b0, d_doe_ff}) - EPOCH_OFFSET;
      // era length is a whole number of weeks: weekday = (doe + 2) mod 7
      e_x_in     = d_doe_ff + 18'd2;
      x_prod     = 36'(e_x_in) * 36'(RECIP_7);
      e_q7_in    = x_prod[35:21];

      wf_full    = e_x_ff - 18'(e_q7_ff) * 18'd7;
      f_wf_in    = wf_full[2:0];
      f_weeks_in = 6'(e_occ_ff - 3'd1) * 6'd7;
      f_dm1_in   = e_dim_ff - 5'd1;

      fwd   = wrap7(4'(f_wday_ff) + 4'd7 - 4'(f_wf_ff));
      tgt   = 6'(fwd) + f_weeks_ff;
      dm7   = (f_dm1_ff >= 5'd28) ? 3'(f_dm1_ff - 5'd28) : 3'd6;
      wl    = wrap7(4'(f_wf_ff) + 4'(dm7));
      back  = wrap7(4'(wl) + 4'd7 - 4'(f_wday_ff));
      delta = (tgt > 6'(f_dm1_ff)) ? 6'(f_dm1_ff) - 6'(back) : tgt;
      g_day_in = f_first_ff + $signed({17'b0, delta});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_year_ff  <= a_year_in;
      a_yy_ff    <= a_yy_in;
      a_month_ff <= a_month_in;
      a_occ_ff   <= a_occ_in;
      a_wday_ff  <= a_wday_in;

      b_year_ff  <= a_year_ff;
      b_yy_ff    <= a_yy_ff;
      b_month_ff <= a_month_ff;
      b_occ_ff   <= a_occ_ff;
      b_wday_ff  <= a_wday_ff;
      b_era_ff   <= b_era_in;
      b_q100_ff  <= b_q100_in;

      c_era_ff   <= b_era_ff;
      c_yoe_ff   <= c_yoe_in;
      c_doy_ff   <= day_of_year(b_month_ff);
      c_dim_ff   <= c_dim_in;
      c_occ_ff   <= b_occ_ff;
      c_wday_ff  <= b_wday_ff;

      d_era_ff   <= c_era_ff;
      d_doe_ff   <= d_doe_in;
      d_dim_ff   <= c_dim_ff;
      d_occ_ff   <= c_occ_ff;
      d_wday_ff  <= c_wday_ff;

      e_first_ff <= e_first_in;
      e_x_ff     <= e_x_in;
      e_q7_ff    <= e_q7_in;
      e_dim_ff   <= d_dim_ff;
      e_occ_ff   <= d_occ_ff;
      e_wday_ff  <= d_wday_ff;

      f_first_ff <= e_first_ff;
      f_wf_ff    <= f_wf_in;
      f_weeks_ff <= f_weeks_in;
      f_dm1_ff   <= f_dm1_in;
      f_wday_ff  <= e_wday_ff;

      g_day_ff   <= g_day_in;
   end

   assign rsp_valid      = valid_ff[6];
   assign rsp_day_number = g_day_ff;

endmodule

FILE: sv/nwom_checker.sv
// ----------------------------------------------------------------------------
// nwom_checker
// Port-level checks of the nth weekday unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "nth_weekday_of_month_unit_assert.svh"

module nwom_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [nwom_pkg::YEAR_W-1:0]           req_year,
   input logic [nwom_pkg::MONTH_W-1:0]          req_month,
   input logic [nwom_pkg::OCC_W-1:0]            req_occurrence,
   input logic [nwom_pkg::WDAY_W-1:0]           req_weekday,
   input logic                                  rsp_valid,
   input logic signed [nwom_pkg::DAY_W-1:0]     rsp_day_number
);

   import nwom_pkg::*;

   logic [YEAR_W+MONTH_W+OCC_W+WDAY_W-1:0] req_word, req_word_prev_ff;
   logic                                   req_repeat;

   assign req_word   = {req_year, req_month, req_occurrence, req_weekday};
   // request ports equal to their copy in req_word_prev_ff
   assign req_repeat = (req_word == req_word_prev_ff);

   always_ff @(posedge clock) begin
      req_word_prev_ff <= req_word;
   end

   // every answer stems from a word that the unit has taken
   `NWOM_ASSERT_RST(a_rsp_has_req, clock, reset,
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY),
      "answer without a request")

   // reset flushes the pipeline
   `NWOM_ASSERT(a_reset_flush, clock, reset |=> !rsp_valid, "answer right after reset")

   `NWOM_ASSERT_RST(a_rsp_range, clock, reset,
      rsp_valid |-> (rsp_day_number >= DAY_MIN) && (rsp_day_number <= DAY_MAX),
      "day count out of range")

   // no state: equal back-to-back requests give equal answers
   `NWOM_ASSERT_RST(a_stateless, clock, reset,
      rsp_valid && $past(rsp_valid) && $past(req_repeat, PIPE_LATENCY)
         |-> rsp_day_number == $past(rsp_day_number),
      "equal requests, different answers")

endmodule

bind nth_weekday_of_month_unit nwom_checker u_nwom_checker (.*);
